>>> rtl/view_cone_circle_visibility_defines.svh
// ----------------------------------------------------------------------------
// View cone circle visibility: assertion macros
// Shared property macros for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VIEW_CONE_CIRCLE_VISIBILITY_DEFINES_SVH
`define VIEW_CONE_CIRCLE_VISIBILITY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VCCV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define VCCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/vccv_pkg.sv
// ----------------------------------------------------------------------------
// View cone circle visibility package
// Field widths, register indexes, verdict codes and payload types.
// ----------------------------------------------------------------------------
package vccv_pkg;

  localparam int CoordW   = 16;
  localparam int DiffW    = 17;
  localparam int EdgeW    = 19;
  localparam int RadW     = 15;
  localparam int TrigW    = 15;
  localparam int RangeW   = 16;
  localparam int DdW      = 34;
  localparam int R2W      = 2 * RadW;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgCosHalfFov = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSinHalfFov = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgViewRange  = 2'd2;

  // Register values after reset.
  localparam logic [TrigW-1:0]  CosHalfFovRst = 15'd23170;
  localparam logic [TrigW-1:0]  SinHalfFovRst = 15'd23170;
  localparam logic [RangeW-1:0] ViewRangeRst  = 16'd16384;

  // Verdict codes.
  localparam logic [1:0] VerdictBeyond  = 2'd0;
  localparam logic [1:0] VerdictOutside = 2'd1;
  localparam logic [1:0] VerdictEdge    = 2'd2;
  localparam logic [1:0] VerdictInside  = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] eye_x;
    logic signed [CoordW-1:0] eye_z;
    logic signed [CoordW-1:0] look_x;
    logic signed [CoordW-1:0] look_z;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_z;
    logic        [RadW-1:0]   radius;
  } in_t;

  typedef struct packed {
    logic       visible;
    logic [1:0] verdict;
  } out_t;

  // Operands of one edge segment test.
  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dz;
    logic signed [EdgeW-1:0] ex;
    logic signed [EdgeW-1:0] ez;
    logic        [DdW-1:0]   dd;
    logic        [R2W-1:0]   r2;
  } edge_in_t;

endpackage

>>> rtl/vccv_edge.sv
// ----------------------------------------------------------------------------
// Edge segment proximity test
// Six-stage pipeline deciding whether a point lies closer than the radius
// to the segment from the origin to the edge vector.
// ----------------------------------------------------------------------------
module vccv_edge (
  input  logic                clk_i,
  input  logic                en_i,
  input  vccv_pkg::edge_in_t  edge_i,
  output logic                near_o
);
  import vccv_pkg::*;

  // Stage 1: products and offset to the far end.
  logic signed [35:0] dxex_q, dzez_q, dxez_q, dzex_q;
  logic signed [37:0] exex_q, ezez_q;
  logic signed [19:0] fx_q, fz_q;
  logic [DdW-1:0]     dd1_q;
  logic [R2W-1:0]     r2_1_q;

  // Stage 2: dot, cross and squared length.
  logic signed [36:0] de_q, cr_q;
  logic [36:0]        ee_q;
  logic signed [39:0] fx2_q, fz2_q;
  logic [DdW-1:0]     dd2_q;
  logic [R2W-1:0]     r2_2_q;

  // Stage 3: magnitudes and region flags.
  logic [40:0]    ff_q;
  logic [36:0]    mag_q, ee3_q;
  logic           le0_q, ge_q;
  logic [DdW-1:0] dd3_q;
  logic [R2W-1:0] r2_3_q;

  // Stage 4: partial products and end point compares.
  logic [55:0] mml_q;
  logic [54:0] mmh_q;
  logic [48:0] rel_q;
  logic [47:0] reh_q;
  logic        le0_4_q, ge_4_q, ddlt_q, fflt_q;

  // Stage 5: assembled products.
  logic [73:0] mm_q;
  logic [66:0] re_q;
  logic        le0_5_q, ge_5_q, ddlt_5_q, fflt_5_q;

  // Stage 6: result.
  logic near_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dxex_q <= edge_i.dx * edge_i.ex;
      dzez_q <= edge_i.dz * edge_i.ez;
      dxez_q <= edge_i.dx * edge_i.ez;
      dzex_q <= edge_i.dz * edge_i.ex;
      exex_q <= edge_i.ex * edge_i.ex;
      ezez_q <= edge_i.ez * edge_i.ez;
      fx_q   <= 20'(edge_i.dx) - 20'(edge_i.ex);
      fz_q   <= 20'(edge_i.dz) - 20'(edge_i.ez);
      dd1_q  <= edge_i.dd;
      r2_1_q <= edge_i.r2;

      de_q   <= 37'(dxex_q) + 37'(dzez_q);
      cr_q   <= 37'(dxez_q) - 37'(dzex_q);
      ee_q   <= 37'(exex_q[35:0]) + 37'(ezez_q[35:0]);
      fx2_q  <= fx_q * fx_q;
      fz2_q  <= fz_q * fz_q;
      dd2_q  <= dd1_q;
      r2_2_q <= r2_1_q;

      ff_q   <= 41'(fx2_q[38:0]) + 41'(fz2_q[38:0]);
      mag_q  <= cr_q[36] ? 37'(-cr_q) : 37'(cr_q);
      le0_q  <= (de_q <= 37'sd0);
      ge_q   <= (38'(de_q) >= $signed({1'b0, ee_q}));
      ee3_q  <= ee_q;
      dd3_q  <= dd2_q;
      r2_3_q <= r2_2_q;

      mml_q   <= 56'(mag_q) * 56'(mag_q[18:0]);
      mmh_q   <= 55'(mag_q) * 55'(mag_q[36:19]);
      rel_q   <= 49'(r2_3_q) * 49'(ee3_q[18:0]);
      reh_q   <= 48'(r2_3_q) * 48'(ee3_q[36:19]);
      le0_4_q <= le0_q;
      ge_4_q  <= ge_q;
      ddlt_q  <= (dd3_q < DdW'(r2_3_q));
      fflt_q  <= (ff_q < 41'(r2_3_q));

      mm_q     <= 74'(mml_q) + (74'(mmh_q) << 19);
      re_q     <= 67'(rel_q) + (67'(reh_q) << 19);
      le0_5_q  <= le0_4_q;
      ge_5_q   <= ge_4_q;
      ddlt_5_q <= ddlt_q;
      fflt_5_q <= fflt_q;

      // Nearest point is the eye, the far end, or inside the segment.
      if (le0_5_q) begin
        near_q <= ddlt_5_q;
      end else if (ge_5_q) begin
        near_q <= fflt_5_q;
      end else begin
        near_q <= (mm_q < 74'(re_q));
      end
    end
  end

  assign near_o = near_q;

endmodule

>>> rtl/view_cone_circle_visibility.sv
// ----------------------------------------------------------------------------
// View cone circle visibility
// One item per cycle.
// The rate is set by the eleven-stage pipeline that advances whenever the
// output register is empty or being taken. Reset clears all valid bits and
// loads the field-of-view and range registers with their default values.
// ----------------------------------------------------------------------------
`include "view_cone_circle_visibility_defines.svh"

module view_cone_circle_visibility (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  vccv_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output vccv_pkg::out_t                   out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [vccv_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [vccv_pkg::CfgDataW-1:0]    cfg_data_i
);
  import vccv_pkg::*;

  localparam int NStg = 11;

  function automatic logic signed [EdgeW-1:0] round_q15(input logic signed [33:0] s);
    logic [33:0] m;
    logic [34:0] t;
    logic [19:0] q;
    m = s[33] ? 34'(-s) : 34'(s);
    t = 35'(m) + 35'd16384;
    q = t[34:15];
    round_q15 = s[33] ? EdgeW'(-q) : EdgeW'(q);
  endfunction

  // Configuration registers.
  logic [TrigW-1:0]  cos_q, sin_q;
  logic [RangeW-1:0] range_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= CosHalfFovRst;
      sin_q   <= SinHalfFovRst;
      range_q <= ViewRangeRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCosHalfFov: cos_q   <= cfg_data_i[TrigW-1:0];
        CfgSinHalfFov: sin_q   <= cfg_data_i[TrigW-1:0];
        CfgViewRange:  range_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid bits.
  logic            en;
  logic [NStg-1:0] vld_q;

  assign en          = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  logic signed [16:0] cs, ss;
  assign cs = 17'(cos_q);
  assign ss = 17'(sin_q);

  // Stage 1: eye-relative vectors.
  logic signed [DiffW-1:0] dx1_q, dz1_q, vx1_q, vz1_q;
  logic [RadW-1:0]         r1_q;

  // Stage 2: products.
  logic signed [DiffW-1:0] dx2_q, dz2_q;
  logic signed [33:0]      pdx_q, pdz_q, pvx_q, pvz_q, pdvx_q, pdvz_q;
  logic signed [33:0]      vxc_q, vzs_q, vzc_q, vxs_q;
  logic [R2W-1:0]          r2_2_q;
  logic [31:0]             rng2_q;

  // Stage 3: sums.
  logic signed [DiffW-1:0] dx3_q, dz3_q;
  logic [DdW-1:0]          dd3_q, vv3_q;
  logic signed [34:0]      dv3_q;
  logic signed [33:0]      spx_q, spz_q, smx_q, smz_q;
  logic [R2W-1:0]          r2_3_q;
  logic                    beyond3_q;

  // Stage 4: rounded edge vectors.
  edge_in_t       ep_q, em_q;
  logic [DdW-1:0] dd4_q, vv4_q;
  logic [33:0]    dvu4_q;
  logic           beyond4_q, vv0_4_q, dd0_4_q, c0_4_q, dvneg4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q <= 17'(in_data_i.point_x) - 17'(in_data_i.eye_x);
      dz1_q <= 17'(in_data_i.point_z) - 17'(in_data_i.eye_z);
      vx1_q <= 17'(in_data_i.look_x) - 17'(in_data_i.eye_x);
      vz1_q <= 17'(in_data_i.look_z) - 17'(in_data_i.eye_z);
      r1_q  <= in_data_i.radius;

      dx2_q  <= dx1_q;
      dz2_q  <= dz1_q;
      pdx_q  <= dx1_q * dx1_q;
      pdz_q  <= dz1_q * dz1_q;
      pvx_q  <= vx1_q * vx1_q;
      pvz_q  <= vz1_q * vz1_q;
      pdvx_q <= dx1_q * vx1_q;
      pdvz_q <= dz1_q * vz1_q;
      vxc_q  <= vx1_q * cs;
      vzs_q  <= vz1_q * ss;
      vzc_q  <= vz1_q * cs;
      vxs_q  <= vx1_q * ss;
      r2_2_q <= R2W'(r1_q) * R2W'(r1_q);
      rng2_q <= 32'(range_q) * 32'(range_q);

      dx3_q     <= dx2_q;
      dz3_q     <= dz2_q;
      dd3_q     <= DdW'(pdx_q[32:0]) + DdW'(pdz_q[32:0]);
      vv3_q     <= DdW'(pvx_q[32:0]) + DdW'(pvz_q[32:0]);
      dv3_q     <= 35'(pdvx_q) + 35'(pdvz_q);
      spx_q     <= vxc_q + vzs_q;
      spz_q     <= vzc_q - vxs_q;
      smx_q     <= vxc_q - vzs_q;
      smz_q     <= vzc_q + vxs_q;
      r2_3_q    <= r2_2_q;
      beyond3_q <= (DdW'(pdx_q[32:0]) + DdW'(pdz_q[32:0])) > DdW'(rng2_q);

      ep_q      <= '{dx: dx3_q, dz: dz3_q, ex: round_q15(spx_q), ez: round_q15(spz_q),
                     dd: dd3_q, r2: r2_3_q};
      em_q      <= '{dx: dx3_q, dz: dz3_q, ex: round_q15(smx_q), ez: round_q15(smz_q),
                     dd: dd3_q, r2: r2_3_q};
      dd4_q     <= dd3_q;
      vv4_q     <= vv3_q;
      dvu4_q    <= dv3_q[33:0];
      beyond4_q <= beyond3_q;
      vv0_4_q   <= (vv3_q == '0);
      dd0_4_q   <= (dd3_q == '0);
      c0_4_q    <= (cos_q == '0);
      dvneg4_q  <= dv3_q[34];
    end
  end

  // Edge segment tests, one unit per edge.
  logic near_p, near_m;

  vccv_edge u_edge_p (.clk_i(clk_i), .en_i(en), .edge_i(ep_q), .near_o(near_p));
  vccv_edge u_edge_m (.clk_i(clk_i), .en_i(en), .edge_i(em_q), .near_o(near_m));

  // Cone test alongside the edge units: dv^2 * 2^30 >= dd * vv * cos^2.
  logic [50:0]  dvl5_q, dvh5_q, ddvl5_q, ddvh5_q;
  logic [29:0]  c2_5_q, c2_6_q;
  logic [67:0]  dv2_6_q, ddvv6_q, dv2_7_q;
  logic [46:0]  q0_7_q, q1_7_q, q2_7_q, q3_7_q;
  logic [97:0]  lhs8_q, rhs8_q;
  logic         inside9_q, inside10_q;
  logic [5:0]   beyond_q;
  logic [3:0]   vv0_q, dd0_q, c0_q, dvneg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvl5_q  <= 51'(dvu4_q) * 51'(dvu4_q[16:0]);
      dvh5_q  <= 51'(dvu4_q) * 51'(dvu4_q[33:17]);
      ddvl5_q <= 51'(dd4_q) * 51'(vv4_q[16:0]);
      ddvh5_q <= 51'(dd4_q) * 51'(vv4_q[33:17]);
      c2_5_q  <= 30'(cos_q) * 30'(cos_q);

      dv2_6_q <= 68'(dvl5_q) + (68'(dvh5_q) << 17);
      ddvv6_q <= 68'(ddvl5_q) + (68'(ddvh5_q) << 17);
      c2_6_q  <= c2_5_q;

      dv2_7_q <= dv2_6_q;
      q0_7_q  <= 47'(ddvv6_q[16:0]) * 47'(c2_6_q);
      q1_7_q  <= 47'(ddvv6_q[33:17]) * 47'(c2_6_q);
      q2_7_q  <= 47'(ddvv6_q[50:34]) * 47'(c2_6_q);
      q3_7_q  <= 47'(ddvv6_q[67:51]) * 47'(c2_6_q);

      lhs8_q <= {dv2_7_q, 30'd0};
      rhs8_q <= 98'(q0_7_q) + (98'(q1_7_q) << 17) + (98'(q2_7_q) << 34)
              + (98'(q3_7_q) << 51);

      // Degenerate view vector or centre take precedence over the ratio.
      priority if (vv0_q[3]) begin
        inside9_q <= 1'b1;
      end else if (dd0_q[3]) begin
        inside9_q <= c0_q[3];
      end else if (dvneg_q[3]) begin
        inside9_q <= 1'b0;
      end else begin
        inside9_q <= !(lhs8_q < rhs8_q);
      end
      inside10_q <= inside9_q;

      beyond_q <= {beyond_q[4:0], beyond4_q};
      vv0_q    <= {vv0_q[2:0], vv0_4_q};
      dd0_q    <= {dd0_q[2:0], dd0_4_q};
      c0_q     <= {c0_q[2:0], c0_4_q};
      dvneg_q  <= {dvneg_q[2:0], dvneg4_q};
    end
  end

  // Output register: range first, then edges, then cone.
  logic [1:0] verdict_d, verdict_q;

  always_comb begin
    priority if (beyond_q[5]) begin
      verdict_d = VerdictBeyond;
    end else if (near_p || near_m) begin
      verdict_d = VerdictEdge;
    end else if (inside10_q) begin
      verdict_d = VerdictInside;
    end else begin
      verdict_d = VerdictOutside;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_data_o.verdict = verdict_q;
  assign out_data_o.visible = verdict_q[1];

  // Checks.
  `VCCV_ASSERT_NEXT(a_enter, in_valid_i && in_ready_o, vld_q[0], "accepted item lost")
  `VCCV_ASSERT_NOW(a_no_block, !out_valid_o, in_ready_o, "input stalled with empty output")
  `VCCV_ASSERT_NEXT(a_reach_out, vld_q[NStg-2] && en, out_valid_o, "item did not reach output")

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// View cone circle visibility testbench
// Drives view queries through the valid/ready input channel, predicts the
// verdict of each query with an integer model of the cone test, and compares
// every output transfer against the oldest prediction. Several field-of-view
// and range settings are applied between phases, extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import vccv_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CfgCosHalfFov;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  view_cone_circle_visibility u_top (.*);

  always #5 clk_i = ~clk_i;

  // Predictor copy of the registers.
  logic [TrigW-1:0] cos_fov = CosHalfFovRst;
  logic [TrigW-1:0] sin_fov = SinHalfFovRst;
  logic [RangeW-1:0] range_q = ViewRangeRst;

  in_t query_q[$];
  out_t verdict_q[$];
  int errors = 0;
  bit in_taken = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Divide a rotation result by 2^15, halves rounded away from zero.
  function automatic longint round_q15(longint x);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + 16384) >>> 15;
    return (x < 0) ? -m : m;
  endfunction

  function automatic bit near_segment(longint dx, longint dz, longint ex, longint ez,
                                      longint dd, longint r2);
    longint de, ee, fx, fz, cr;
    logic [127:0] lhs, rhs;
    de = dx * ex + dz * ez;
    ee = ex * ex + ez * ez;
    if (de <= 0) return dd < r2;
    if (de >= ee) begin
      fx = dx - ex;
      fz = dz - ez;
      return (fx * fx + fz * fz) < r2;
    end
    cr = dx * ez - dz * ex;
    if (cr < 0) cr = -cr;
    lhs = 128'(cr) * 128'(cr);
    rhs = 128'(r2) * 128'(ee);
    return lhs < rhs;
  endfunction

  function automatic out_t cone_verdict(in_t q);
    longint dx, dz, vx, vz, r2, dd, vv, c, s, px, pz, mx, mz, dv;
    logic [127:0] lhs, rhs;
    bit in_cone;
    out_t o;
    dx = longint'(q.point_x) - longint'(q.eye_x);
    dz = longint'(q.point_z) - longint'(q.eye_z);
    vx = longint'(q.look_x) - longint'(q.eye_x);
    vz = longint'(q.look_z) - longint'(q.eye_z);
    r2 = longint'(q.radius) * longint'(q.radius);
    dd = dx * dx + dz * dz;
    vv = vx * vx + vz * vz;
    c = longint'(cos_fov);
    s = longint'(sin_fov);
    if (dd > longint'(range_q) * longint'(range_q)) begin
      o.verdict = VerdictBeyond;
    end else begin
      px = round_q15(vx * c + vz * s);
      pz = round_q15(vz * c - vx * s);
      mx = round_q15(vx * c - vz * s);
      mz = round_q15(vz * c + vx * s);
      if (near_segment(dx, dz, px, pz, dd, r2) || near_segment(dx, dz, mx, mz, dd, r2)) begin
        o.verdict = VerdictEdge;
      end else begin
        dv = dx * vx + dz * vz;
        if (vv == 0) in_cone = 1'b1;
        else if (dd == 0) in_cone = (c == 0);
        else if (dv < 0) in_cone = 1'b0;
        else begin
          lhs = (128'(dv) * 128'(dv)) << 30;
          rhs = 128'(dd) * 128'(vv) * 128'(c * c);
          in_cone = !(lhs < rhs);
        end
        o.verdict = in_cone ? VerdictInside : VerdictOutside;
      end
    end
    o.visible = (o.verdict == VerdictEdge) || (o.verdict == VerdictInside);
    return o;
  endfunction

  task automatic report(string what, out_t got, out_t want);
    errors++;
    $display("mismatch %s: got visible=%0d verdict=%0d, want visible=%0d verdict=%0d",
             what, got.visible, got.verdict, want.visible, want.verdict);
  endtask

  // Driver: one transfer per accepted query, random gaps in between.
  always @(negedge clk_i) begin
    bit free;
    if (rst_ni) begin
      free = !in_valid_i || in_taken;
      if (in_taken) begin
        in_gap = gap_len();
      end
      if (free) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (query_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= query_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap = gap_len();
      end
    end
  end

  // Monitor: record input transfers and check each output transfer against
  // the oldest prediction.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        verdict_q.push_back(cone_verdict(in_data_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          report("unexpected transfer", out_data_o, '0);
        end else begin
          want = verdict_q.pop_front();
          if (out_data_o.visible !== want.visible) report("visible", out_data_o, want);
          if (out_data_o.verdict !== want.verdict) report("verdict", out_data_o, want);
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgCosHalfFov: cos_fov = val[TrigW-1:0];
      CfgSinHalfFov: sin_fov = val[TrigW-1:0];
      default: range_q = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] coord_rand(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 4096)) - 2048);
      default: return 16'($signed($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  function automatic in_t rand_query();
    in_t q;
    int mode;
    mode = $urandom_range(0, 3);
    q.eye_x = coord_rand(mode);
    q.eye_z = coord_rand(mode);
    q.look_x = ($urandom_range(0, 9) == 0) ? q.eye_x : q.eye_x + coord_rand(mode);
    q.look_z = q.look_x == q.eye_x ? q.eye_z : q.eye_z + coord_rand(mode);
    q.point_x = ($urandom_range(0, 19) == 0) ? q.eye_x : q.eye_x + coord_rand(mode);
    q.point_z = q.point_x == q.eye_x ? q.eye_z : q.eye_z + coord_rand(mode);
    case ($urandom_range(0, 3))
      0: q.radius = '0;
      1: q.radius = 15'($urandom);
      default: q.radius = 15'($urandom_range(0, 1024));
    endcase
    return q;
  endfunction

  task automatic drain();
    while (query_q.size() > 0 || in_valid_i || verdict_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic run_phase(int n);
    repeat (n) query_q.push_back(rand_query());
    drain();
  endtask

  initial begin
    in_t q;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, degenerate look and centre, radius edges.
    q = '0;
    query_q.push_back(q);                         // all at the eye
    q.look_x = 16'sd256;
    query_q.push_back(q);                         // centre at eye
    q.radius = 15'h7fff;
    query_q.push_back(q);
    q = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 15'h7fff};
    query_q.push_back(q);
    q = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 15'h0};
    query_q.push_back(q);
    q = '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd512, 15'd0};
    query_q.push_back(q);                         // straight ahead
    q = '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, -16'sd512, 15'd0};
    query_q.push_back(q);                         // behind
    q = '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd512, 16'sd0, 15'd600};
    query_q.push_back(q);                         // touching an edge
    q = '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd16384, 15'd0};
    query_q.push_back(q);                         // exactly at range
    q = '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd16385, 15'd0};
    query_q.push_back(q);                         // just past range
    q = '{16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd256, 16'sd0, 15'd0};
    query_q.push_back(q);                         // on the cone boundary
    drain();

    run_phase(150);
    write_reg(CfgCosHalfFov, 16'h0000);
    write_reg(CfgSinHalfFov, 16'h7fff);
    write_reg(CfgViewRange, 16'hffff);
    run_phase(100);
    write_reg(CfgCosHalfFov, 16'hffff);
    write_reg(CfgSinHalfFov, 16'h0000);
    write_reg(CfgViewRange, 16'h0000);
    run_phase(50);
    write_reg(CfgCosHalfFov, 16'($urandom));
    write_reg(CfgSinHalfFov, 16'($urandom));
    write_reg(CfgViewRange, 16'($urandom_range(256, 65535)));
    run_phase(150);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
